FILE: rtl/mme_pkg.sv
// shared types, constants and helpers of the matrix multiply engine
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int VALUE_BITS  = 16;

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int MUL_W       = 2 * VALUE_BITS;

    // fixed field widths of the ports
    localparam int DIM_W       = 4;
    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 6;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 36;
    localparam int REG_IDX_W   = 2;
    localparam int SIZE_W      = 2 * DIM_W;

    localparam logic [DIM_W-1:0] CFG_RESET = 4'd8;

    localparam logic [REG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_B_COLS = 2'd3;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_MULT   = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_ERR
    } t_state;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     addr;
        logic [VALUE_BITS-1:0] data;
    } t_store_wr;

    // tags that travel with one multiply-accumulate term
    typedef struct packed {
        logic vld;
        logic first;
        logic last_term;
        logic last_out;
        logic zero;
    } t_term;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        return (r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r;
    endfunction

    // low VALUE_BITS of the zero-extended input word
    function automatic logic [VALUE_BITS-1:0] to_store(input logic [ELEM_W-1:0] v);
        logic [31:0] wide;
        wide = {16'b0, v};
        return wide[VALUE_BITS-1:0];
    endfunction

endpackage

FILE: rtl/mme_store.sv
// element store: one write port, one registered read port, per-entry valid bits
module mme_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mme_pkg::t_store_wr               i_wr,
    input  logic                             i_rd_en,
    input  logic [mme_pkg::ADDR_W-1:0]       i_rd_addr,
    output logic signed [mme_pkg::VALUE_BITS-1:0] o_rd_data
);
    import mme_pkg::*;

    logic [VALUE_BITS-1:0]  r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_vld;
    logic [VALUE_BITS-1:0]  r_rd_data;
    logic                   r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_vld[i_rd_addr];
            end
        end
    end

    // never written entries read as zero
    assign o_rd_data = r_rd_ok ? $signed(r_rd_data) : '0;

endmodule

FILE: rtl/matrix_multiply_engine.sv
// matrix multiply engine: element stores, term sequencer, shared multiply-accumulate
// loads are accepted back to back while idle
// a multiply issues one term per cycle unless the output stalls, to a single multiplier:
// a_rows*b_cols*max(a_cols,1) terms; results pass the read, multiply and output registers
// a mismatch answers after the drain; output backpressure freezes the whole term pipeline
// synchronous active-low reset: dimension registers to 8, stores read as zero until loaded
module matrix_multiply_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mme_pkg::FUNC_W-1:0]          i_func,
    input  logic [mme_pkg::IDX_W-1:0]           i_element_index,
    input  logic signed [mme_pkg::ELEM_W-1:0]   i_element_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mme_pkg::PROD_W-1:0]   o_product_value,
    output logic                                o_is_last,
    output logic                                o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mme_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]           i_cfg_data
);
    import mme_pkg::*;

    t_state r_state, n_state;

    logic [DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [DIM_W-1:0] ar, ac, bc, br;
    logic [SIZE_W-1:0] a_size, b_size;

    logic [CNT_W-1:0]  r_i, r_j, r_k;
    logic [ADDR_W-1:0] r_a_base, r_a_addr, r_b_addr;

    t_term r_s1, r_s2, cur_term;
    logic signed [MUL_W-1:0]  r_prod;
    logic signed [PROD_W-1:0] r_acc, acc_sum, acc_base;
    logic signed [VALUE_BITS-1:0] a_rd, b_rd;

    t_store_wr st_a_wr, st_b_wr;

    logic in_acc, adv, issue, err_out;
    logic k_last, j_last, i_last, run_done;
    logic mismatch, empty_run;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= CFG_RESET;
            r_a_cols <= CFG_RESET;
            r_b_rows <= CFG_RESET;
            r_b_cols <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_A_ROWS: r_a_rows <= i_cfg_data;
                REG_A_COLS: r_a_cols <= i_cfg_data;
                REG_B_ROWS: r_b_rows <= i_cfg_data;
                REG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ar = eff_dim(r_a_rows);
    assign ac = eff_dim(r_a_cols);
    assign br = eff_dim(r_b_rows);
    assign bc = eff_dim(r_b_cols);
    assign a_size = SIZE_W'(ar) * SIZE_W'(ac);
    assign b_size = SIZE_W'(br) * SIZE_W'(bc);

    assign mismatch  = (r_a_cols != r_b_rows);
    assign empty_run = (ar == '0) || (bc == '0);

    assign in_acc  = i_valid && !o_stall;
    assign adv     = !o_valid || !i_stall;
    assign issue   = (r_state == S_RUN) && adv;
    assign err_out = (r_state == S_ERR) && adv && !r_s1.vld && !r_s2.vld;

    // element loads
    always_comb begin
        st_a_wr.we   = in_acc && (i_func == FUNC_LOAD_A)
                       && (SIZE_W'(i_element_index) < a_size)
                       && (32'(i_element_index) < STORE_DEPTH);
        st_a_wr.addr = i_element_index[ADDR_W-1:0];
        st_a_wr.data = to_store(i_element_value);
        st_b_wr.we   = in_acc && (i_func == FUNC_LOAD_B)
                       && (SIZE_W'(i_element_index) < b_size)
                       && (32'(i_element_index) < STORE_DEPTH);
        st_b_wr.addr = i_element_index[ADDR_W-1:0];
        st_b_wr.data = to_store(i_element_value);
    end

    mme_store u_store_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (st_a_wr),
        .i_rd_en   (issue),
        .i_rd_addr (r_a_addr),
        .o_rd_data (a_rd)
    );

    mme_store u_store_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (st_b_wr),
        .i_rd_en   (issue),
        .i_rd_addr (r_b_addr),
        .o_rd_data (b_rd)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign k_last   = (ac == '0) || (DIM_W'(r_k) == ac - DIM_W'(1));
    assign j_last   = (DIM_W'(r_j) == bc - DIM_W'(1));
    assign i_last   = (DIM_W'(r_i) == ar - DIM_W'(1));
    assign run_done = k_last && j_last && i_last;

    always_comb begin
        n_state = r_state;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_func == FUNC_MULT)) begin
                    if (mismatch) begin
                        n_state = S_ERR;
                    end else if (!empty_run) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (issue && run_done) begin
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                if (err_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cur_term.vld       = 1'b1;
        cur_term.first     = (r_k == '0);
        cur_term.last_term = k_last;
        cur_term.last_out  = run_done;
        cur_term.zero      = (ac == '0);
    end

    // term counters and store addresses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_a_base <= '0;
            r_a_addr <= '0;
            r_b_addr <= '0;
        end else if (r_state == S_IDLE) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_a_base <= '0;
            r_a_addr <= '0;
            r_b_addr <= '0;
        end else if (issue) begin
            if (!k_last) begin
                r_k      <= CNT_W'(r_k + 1'b1);
                r_a_addr <= ADDR_W'(r_a_addr + 1'b1);
                r_b_addr <= ADDR_W'(r_b_addr + ADDR_W'(bc));
            end else begin
                r_k <= '0;
                if (!j_last) begin
                    r_j      <= CNT_W'(r_j + 1'b1);
                    r_a_addr <= r_a_base;
                    r_b_addr <= ADDR_W'(ADDR_W'(r_j) + 1'b1);
                end else begin
                    r_j      <= '0;
                    r_i      <= CNT_W'(r_i + 1'b1);
                    r_a_base <= ADDR_W'(r_a_base + ADDR_W'(ac));
                    r_a_addr <= ADDR_W'(r_a_base + ADDR_W'(ac));
                    r_b_addr <= '0;
                end
            end
        end
    end

    // term pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (adv) begin
            r_s1 <= issue ? cur_term : '0;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_s1.zero) begin
                r_prod <= '0;
            end else begin
                r_prod <= a_rd * b_rd;
            end
        end
    end

    assign acc_base = r_s2.first ? '0 : r_acc;
    assign acc_sum  = acc_base + PROD_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (adv && r_s2.vld) begin
            r_acc <= acc_sum;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= (r_s2.vld && r_s2.last_term) || err_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2.vld && r_s2.last_term) begin
            o_product_value <= acc_sum;
            o_is_last       <= r_s2.last_out;
            o_status        <= STATUS_OK;
        end else if (err_out) begin
            o_product_value <= '0;
            o_is_last       <= 1'b1;
            o_status        <= STATUS_MISMATCH;
        end
    end

`ifndef SYNTH
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_MISMATCH)) |-> (o_is_last && (o_product_value == '0)))
        else $error("mismatch word must be last and zero");

    a_err_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ERR) && (n_state == S_IDLE)) |-> (!r_s1.vld && !r_s2.vld))
        else $error("mismatch word issued with terms still in flight");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && (r_state == S_IDLE)))
        else $error("reset did not clear output and sequencer");

    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ERR) && adv) |=> !r_s1.vld)
        else $error("term issued during mismatch handling");
`endif

endmodule
